FILE: sv/lcd_text_to_i2c_nibble_writes_unit_assert.svh
// ----------------------------------------------------------------------------
// lcd text to i2c nibble writes - assertion macros
// Shared property forms for the checker, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_TEXT_TO_I2C_NIBBLE_WRITES_UNIT_ASSERT_SVH
`define LCD_TEXT_TO_I2C_NIBBLE_WRITES_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define LCDN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define LCDN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lcdn_pkg.sv
// ----------------------------------------------------------------------------
// lcdn_pkg
// Types, constants and lookup functions for the lcd nibble write unit.
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // request kinds
    typedef enum logic [2:0] {
        REQ_TEXT  = 3'd0,
        REQ_CMD   = 3'd1,
        REQ_DATA  = 3'd2,
        REQ_LINE  = 3'd3,
        REQ_SLOT  = 3'd4
    } t_req;

    // configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_BACKLIGHT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_READY     = 2'd1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // lcd byte constants
    localparam logic [7:0] SPACE      = 8'h20;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] LEAD_C3    = 8'hC3;
    localparam logic [7:0] LEAD_C4    = 8'hC4;
    localparam logic [7:0] LEAD_C8    = 8'hC8;
    localparam logic [7:0] CGRAM_BASE = 8'h40;
    localparam logic       RS_DATA    = 1'b1;
    localparam logic       RS_CMD     = 1'b0;

    // write steps within one lcd byte
    localparam logic [2:0] STEP_EN_HI = 3'd1;
    localparam logic [2:0] STEP_LO    = 3'd3;
    localparam logic [2:0] STEP_EN_LO = 3'd4;
    localparam logic [2:0] STEP_LAST  = 3'd5;

    localparam int NumPairs = 10;

    // input beat
    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] value;
        logic       text_last;
    } t_in;

    // output beat
    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last;
    } t_out;

    // one queued job: one or two lcd bytes sharing a register select
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        logic       rs;
    } t_job;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
    } t_pair;

    localparam logic [7:0] PAIR_LEAD [NumPairs] = '{
        8'hC4, 8'hC4, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC8, 8'hC8, 8'hC8, 8'hC8
    };
    localparam logic [7:0] PAIR_TAIL [NumPairs] = '{
        8'h83, 8'h82, 8'hA2, 8'h82, 8'hAE, 8'h8E, 8'h99, 8'h98, 8'h9B, 8'h9A
    };

    // ddram address of a display line
    function automatic logic [7:0] line_addr(input logic [1:0] line);
        logic [7:0] a;
        case (line)
            2'd0: a = 8'h80;
            2'd1: a = 8'hC0;
            2'd2: a = 8'h94;
            2'd3: a = 8'hD4;
            default: a = 8'h80;
        endcase
        return a;
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b == LEAD_C3) || (b == LEAD_C4) || (b == LEAD_C8);
    endfunction

    function automatic logic [7:0] printable(input logic [7:0] b);
        return ((b >= PRINT_LO) && (b <= PRINT_HI)) ? b : SPACE;
    endfunction

    // two-byte diacritic to cgram code, first match wins
    function automatic t_pair pair_map(input logic [7:0] lead, input logic [7:0] tail);
        t_pair p;
        p = '0;
        for (int i = NumPairs - 1; i >= 0; i--) begin
            if (PAIR_LEAD[i] == lead && PAIR_TAIL[i] == tail) begin
                p.hit  = 1'b1;
                p.code = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: sv/lcdn_front.sv
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts request beats, decodes utf-8 pairs and line/slot requests, and
// pushes at most one job of one or two lcd bytes into the queue.
// ----------------------------------------------------------------------------
module lcdn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_display_ready,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lcdn_pkg::t_in i_in_data,
    input  logic          i_q_ready,
    output logic          o_push,
    output lcdn_pkg::t_job o_job
);
    import lcdn_pkg::*;

    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_lead, n_pend_lead;
    logic       accept;
    logic       has_job;
    logic       hold;
    logic [7:0] v;
    t_pair      pair;
    t_job       job;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign v          = i_in_data.value;
    assign hold       = is_lead(v) && !i_in_data.text_last;
    assign pair       = pair_map(r_pend_lead, v);

    // classify the request
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_lead  = r_pend_lead;
        has_job      = 1'b0;
        job          = '0;
        case (t_req'(i_in_data.req_type))
            REQ_TEXT: begin
                if (i_display_ready) begin
                    job.rs = RS_DATA;
                    if (r_pend_valid) begin
                        n_pend_valid = 1'b0;
                        n_pend_lead  = '0;
                        has_job      = 1'b1;
                        if (pair.hit) begin
                            job.b0 = {4'h0, pair.code};
                        end else begin
                            job.b0 = SPACE;
                            if (hold) begin
                                n_pend_valid = 1'b1;
                                n_pend_lead  = v;
                            end else begin
                                job.two = 1'b1;
                                job.b1  = printable(v);
                            end
                        end
                    end else if (hold) begin
                        n_pend_valid = 1'b1;
                        n_pend_lead  = v;
                    end else begin
                        has_job = 1'b1;
                        job.b0  = printable(v);
                    end
                end
            end
            REQ_CMD: begin
                has_job = 1'b1;
                job.b0  = v;
                job.rs  = RS_CMD;
            end
            REQ_DATA: begin
                has_job = 1'b1;
                job.b0  = v;
                job.rs  = RS_DATA;
            end
            REQ_LINE: begin
                has_job = i_display_ready;
                job.b0  = line_addr(v[1:0]);
                job.rs  = RS_CMD;
            end
            REQ_SLOT: begin
                has_job = 1'b1;
                job.b0  = CGRAM_BASE | {2'b00, v[2:0], 3'b000};
                job.rs  = RS_CMD;
            end
            default: begin
                has_job = 1'b0;
            end
        endcase
    end

    assign o_push = accept && has_job;
    assign o_job  = job;

    // held lead byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_lead  <= '0;
        end else if (accept) begin
            r_pend_valid <= n_pend_valid;
            r_pend_lead  <= n_pend_lead;
        end
    end

endmodule

FILE: sv/lcdn_queue.sv
// ----------------------------------------------------------------------------
// lcdn_queue
// Small job queue between the front decoder and the nibble sequencer.
// ----------------------------------------------------------------------------
module lcdn_queue #(
    parameter int DEPTH = lcdn_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lcdn_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output lcdn_pkg::t_job o_job,
    input  logic           i_pop
);
    import lcdn_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointer wrap
    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/lcdn_back.sv
// ----------------------------------------------------------------------------
// lcdn_back
// Expands each queued job into six expander writes per lcd byte and holds
// the current write in an output register.
// ----------------------------------------------------------------------------
module lcdn_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_backlight,
    input  logic           i_q_valid,
    input  lcdn_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lcdn_pkg::t_out o_out_data
);
    import lcdn_pkg::*;

    logic [2:0] r_step, n_step;
    logic       r_half, n_half;
    logic       r_out_valid;
    t_out       r_out_data, n_out_data;
    logic       adv;
    logic       fin_byte, fin_job;
    logic [7:0] cur_byte;
    logic [3:0] nib;
    logic       en;

    // advance when a job waits and the output slot frees up
    assign adv      = i_q_valid && (!r_out_valid || i_out_ready);
    assign cur_byte = r_half ? i_job.b1 : i_job.b0;
    assign nib      = (r_step < STEP_LO) ? cur_byte[7:4] : cur_byte[3:0];
    assign en       = (r_step == STEP_EN_HI) || (r_step == STEP_EN_LO);
    assign fin_byte = (r_step == STEP_LAST);
    assign fin_job  = fin_byte && (r_half || !i_job.two);
    assign o_pop    = adv && fin_job;

    // next write and sequence position
    always_comb begin
        n_out_data.expander_byte = {nib, i_backlight, en, 1'b0, i_job.rs};
        n_out_data.last          = fin_job;
        n_step                   = fin_byte ? '0 : r_step + 1'b1;
        n_half                   = fin_byte ? !fin_job : r_half;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_half      <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_step      <= n_step;
            r_half      <= n_half;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/lcd_text_to_i2c_nibble_writes_unit.sv
// ----------------------------------------------------------------------------
// lcd_text_to_i2c_nibble_writes_unit
// Character lcd 4-bit writes through an i2c port expander.
// ----------------------------------------------------------------------------
// Each accepted request becomes zero, one or two lcd bytes, and each lcd
// byte leaves as six expander beats (high nibble, with enable, without
// enable, then the same for the low nibble), one beat per cycle while the
// output is taken. Most requests yield one lcd byte, and a text byte that
// flushes a held utf-8 lead byte without forming a pair can yield two;
// held leads and dropped requests yield no output beats. The decoder
// takes a new request every cycle while the job queue has room, so
// requests keep arriving while earlier bytes are still being written out.
module lcd_text_to_i2c_nibble_writes_unit #(
    parameter int QUEUE_DEPTH = lcdn_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcdn_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lcdn_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lcdn_pkg::t_out                o_out_data
);
    import lcdn_pkg::*;

    logic r_backlight;
    logic r_ready;
    logic push, pop;
    logic q_ready, q_valid;
    t_job push_job, head_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
            r_ready     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BACKLIGHT: r_backlight <= i_cfg_data;
                CFG_READY:     r_ready     <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // request decode
    lcdn_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_display_ready(r_ready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_q_ready      (q_ready),
        .o_push         (push),
        .o_job          (push_job)
    );

    // job queue
    lcdn_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_job  (head_job),
        .i_pop  (pop)
    );

    // nibble sequencer
    lcdn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_backlight(r_backlight),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

FILE: sv/lcdn_checker.sv
// ----------------------------------------------------------------------------
// lcdn_checker
// Port-level checks on the expander beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_text_to_i2c_nibble_writes_unit_assert.svh"

module lcdn_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lcdn_pkg::t_out o_out_data
);
    import lcdn_pkg::*;

    // bit 1 of the expander is never driven
    `LCDN_ASSERT_SAME(a_bit1_zero, o_out_valid, !o_out_data.expander_byte[1], "bit 1 set")

    // the final beat of a request always has enable low
    `LCDN_ASSERT_SAME(a_last_no_en, o_out_valid && o_out_data.last, !o_out_data.expander_byte[2], "last beat with enable")

    // an enable pulse is followed at once by the same nibble with enable low
    `LCDN_ASSERT_NEXT(a_en_fall, o_out_valid && i_out_ready && o_out_data.expander_byte[2], o_out_valid && !o_out_data.expander_byte[2] && (o_out_data.expander_byte[7:4] == $past(o_out_data.expander_byte[7:4])), "enable not released")

    // a stalled beat holds
    `LCDN_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled beat changed")

endmodule

bind lcd_text_to_i2c_nibble_writes_unit lcdn_checker u_lcdn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
